### rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, types and the pattern function for the 3x3 LBP stream unit.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int CODE_BITS  = 9;
    localparam int WIDTH_BITS = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int CFG_BITS   = 13;
    localparam int OUT_TDATA_BITS = 16;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [CODE_BITS-1:0]  code_t;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        code_t code;
        logic  last;
    } result_t;

    // win: [0..2] column c-2 top/mid/bottom, [3..5] column c-1 top/mid/bottom
    function automatic code_t lbp_code_f(
        input pixel_t w0, input pixel_t w1, input pixel_t w2,
        input pixel_t w3, input pixel_t w4, input pixel_t w5,
        input pixel_t up, input pixel_t mid, input pixel_t p);
        code_t c;
        c    = '0;
        c[1] = (w4 >= w0);
        c[2] = (w4 >= w3);
        c[3] = (w4 >= up);
        c[4] = (w4 >= w1);
        c[5] = (w4 >= mid);
        c[6] = (w4 >= w2);
        c[7] = (w4 >= w5);
        c[8] = (w4 >= p);
        return c;
    endfunction

endpackage

### rtl/lbp_3x3_raster_stream_unit.sv
// ----------------------------------------------------------------------------
// lbp_3x3_raster_stream_unit
// 3x3 local binary pattern over a raster pixel stream, interior positions only.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock unless the input is stalled. Both line
// stores share one 1024 x 16 RAM (upper row in the low byte, middle row in
// the high byte) with a registered read port; the entry for the next column
// is read in the cycle the current pixel is taken, so each pixel is
// read-modify-written and the sustained rate outside stalls is one pixel per
// cycle. The code of the pixel that completes a window is registered into the
// output register or the skid stage behind it, so input is stalled only when
// both hold undelivered codes. Rows 0-1 and columns 0-1 of every row give no
// code; a frame of h x w gives (h-2)x(w-2) codes, the last one flagged with
// tlast. A register write restarts the frame. No clearing pass after reset: a
// line store entry is always written before any code uses it.
module lbp_3x3_raster_stream_unit
    import lbp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [CFG_BITS-1:0]        cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [PIXEL_BITS-1:0]      s_axis_tdata,   // [7:0] pixel
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]  m_axis_tdata,   // [8:0] lbp_code, rest zero
    output logic                       m_axis_tlast    // frame_last
);

    localparam logic [WIDTH_BITS-1:0]  W_MIN  = WIDTH_BITS'(3);
    localparam logic [WIDTH_BITS-1:0]  W_MAX  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] H_MIN  = HEIGHT_BITS'(3);
    localparam logic [HEIGHT_BITS-1:0] H_MAX  = HEIGHT_BITS'(MAX_HEIGHT);

    // line store RAM
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] mem_q;

    col_t    w_last_reg, w_last_next;
    row_t    h_last_reg, h_last_next;
    col_t    col_reg, col_next;
    row_t    row_reg, row_next;
    pixel_t  win_reg [6];

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic    accept;
    logic    res_valid;
    result_t res;
    pixel_t  up_px, mid_px, in_px;
    logic    drain;

    logic [WIDTH_BITS-1:0]  cfg_w;
    logic [HEIGHT_BITS-1:0] cfg_h;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign up_px  = mem_q[PIXEL_BITS-1:0];
    assign mid_px = mem_q[2*PIXEL_BITS-1:PIXEL_BITS];
    assign in_px  = s_axis_tdata;

    assign res_valid = accept && !cfg_we && (row_reg >= row_t'(2)) && (col_reg >= col_t'(2));
    assign res.code  = lbp_code_f(win_reg[0], win_reg[1], win_reg[2],
                                  win_reg[3], win_reg[4], win_reg[5],
                                  up_px, mid_px, in_px);
    assign res.last  = (row_reg == h_last_reg) && (col_reg == w_last_reg);

    assign drain = !out_valid_reg || m_axis_tready;

    // clamped last column / last row of a register write
    always_comb
    begin
        cfg_w       = cfg_wdata[WIDTH_BITS-1:0];
        cfg_h       = cfg_wdata[HEIGHT_BITS-1:0];
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_IMAGE_WIDTH:
                begin
                    if (cfg_w < W_MIN)
                        w_last_next = col_t'(2);
                    else if (cfg_w > W_MAX)
                        w_last_next = col_t'(MAX_WIDTH - 1);
                    else
                        w_last_next = col_t'(cfg_w - WIDTH_BITS'(1));
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (cfg_h < H_MIN)
                        h_last_next = row_t'(2);
                    else if (cfg_h > H_MAX)
                        h_last_next = row_t'(MAX_HEIGHT - 1);
                    else
                        h_last_next = row_t'(cfg_h - HEIGHT_BITS'(1));
                end
                default:
                begin
                    w_last_next = w_last_reg;
                    h_last_next = h_last_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + row_t'(1);
            end
            else
            begin
                col_next = col_reg + col_t'(1);
            end
        end
    end

    // RAM: write the current column, prefetch the column of the next beat
    always_ff @(posedge clk)
    begin
        if (accept && !cfg_we)
            line_mem[col_reg] <= {in_px, mid_px};
        mem_q <= line_mem[col_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= col_t'(63);
            h_last_reg <= row_t'(63);
            col_reg    <= '0;
            row_reg    <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (cfg_we)
            begin
                for (int i = 0; i < 6; i++)
                    win_reg[i] <= '0;
            end
            else if (accept)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= up_px;
                win_reg[4] <= mid_px;
                win_reg[5] <= in_px;
            end
        end
    end

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end
            else
            begin
                out_valid_reg  <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg  <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'(out_reg.code);
    assign m_axis_tlast  = out_reg.last;

    // ------------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a code while output register is empty");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_last_reg) && (row_reg <= h_last_reg))
        else $error("raster position outside frame");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && col_reg == w_last_reg && row_reg == h_last_reg)
        |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not wrap after its last pixel");

    a_last_code_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && col_reg == w_last_reg && row_reg == h_last_reg
         && drain && !skid_valid_reg)
        |=> out_valid_reg && out_reg.last)
        else $error("final code of frame not flagged");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg && $stable(out_reg))
        else $error("waiting code changed under back-pressure");

endmodule

### test/lbp_3x3_raster_stream_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_3x3_raster_stream_unit_test
// Self-checking bench for the 3x3 LBP raster stream unit.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order from a queue. Each accepted beat goes
// through a local 3x3 window model that queues the expected code and its
// frame-end flag. Output beats are checked in order against that queue.
// Frame sizes start at 3x3, with a short run at the 1024-column clamp, and
// include register values outside both clamps. Stimulus starts with a partial
// frame at the reset geometry and a few hand-built frames, then moves on to
// random frames, with partial frames cut short by a register write. The sender
// and receiver idle in several mixes, and the receiver holds off once long
// enough to back the block up onto its input.
// ----------------------------------------------------------------------------
module lbp_3x3_raster_stream_unit_test;
    import lbp_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 450;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    cfg_index_t                cfg_addr      = CFG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0]       cfg_wdata     = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [PIXEL_BITS-1:0]     s_axis_tdata  = '0;   // [7:0] pixel
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;         // [8:0] lbp_code, rest zero
    logic                      m_axis_tlast;         // frame_last

    lbp_3x3_raster_stream_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // pixel stream, filled by the sequence below, never popped
    pixel_t  pixel_list[$];
    int      pixels_taken  = 0;
    int      offered_index = -1;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_off_requests = 0;
    int      hold_off_served   = 0;
    int      hold_left         = 0;

    // hand-built 3x3 frame with mixed bits
    pixel_t  mixed_frame [9] = '{8'd99, 8'd101, 8'd100, 8'd200, 8'd100,
                                 8'd0, 8'd101, 8'd100, 8'd255};

    // window model state
    logic [WIDTH_BITS-1:0]  width_reg  = 11'd64;
    logic [HEIGHT_BITS-1:0] height_reg = 13'd64;
    pixel_t                 upper_row [MAX_WIDTH];
    pixel_t                 middle_row [MAX_WIDTH];
    pixel_t                 window_px [6];
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;

    result_t code_queue[$];
    result_t next_code;
    int      error_count   = 0;
    int      codes_checked = 0;
    int      frames_closed = 0;

    function automatic int unsigned eff_size(input int unsigned value, input int unsigned limit);
        if (value < 3)
            return 3;
        if (value > limit)
            return limit;
        return value;
    endfunction

    task automatic restart_window();
        col_pos = 0;
        row_pos = 0;
        foreach (window_px[i])
            window_px[i] = '0;
    endtask

    // window_px: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
    task automatic predict_window(input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t      up;
        pixel_t      mid;
        pixel_t      ctr;
        result_t     res;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        up  = upper_row[c];
        mid = middle_row[c];
        if (r >= 2 && c >= 2)
        begin
            ctr = window_px[4];
            res.code    = '0;
            res.code[1] = (ctr >= window_px[0]);
            res.code[2] = (ctr >= window_px[3]);
            res.code[3] = (ctr >= up);
            res.code[4] = (ctr >= window_px[1]);
            res.code[5] = (ctr >= mid);
            res.code[6] = (ctr >= window_px[2]);
            res.code[7] = (ctr >= window_px[5]);
            res.code[8] = (ctr >= px);
            res.last    = (r == h - 1 && c == w - 1);
            code_queue = {code_queue, res};
        end
        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = up;
        window_px[4] = mid;
        window_px[5] = px;
        upper_row[c]  = mid;
        middle_row[c] = px;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // sender: a beat stays up until taken
    always @(negedge clk)
    begin
        if (!(s_axis_tvalid && offered_index == pixels_taken))
        begin
            if (rst_n && pixels_taken < pixel_list.size()
                && $urandom_range(1, 100) > send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_list[pixels_taken];
                offered_index = pixels_taken;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_requests != hold_off_served)
        begin
            hold_off_served = hold_off_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[HEIGHT_BITS-1:0];
                    default: ;
                endcase
                restart_window();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_window(s_axis_tdata);
                pixels_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (code_queue.size() == 0)
                begin
                    $error("lbp_code %0d arrived with no window pending",
                           m_axis_tdata[CODE_BITS-1:0]);
                    error_count++;
                end
                else
                begin
                    next_code = code_queue.pop_front();
                    if (m_axis_tdata[CODE_BITS-1:0] !== next_code.code)
                    begin
                        $error("lbp_code: expected %0d, got %0d",
                               next_code.code, m_axis_tdata[CODE_BITS-1:0]);
                        error_count++;
                    end
                    if (m_axis_tlast !== next_code.last)
                    begin
                        $error("frame_last: expected %0b, got %0b",
                               next_code.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tdata[OUT_TDATA_BITS-1:CODE_BITS] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[OUT_TDATA_BITS-1:CODE_BITS]);
                        error_count++;
                    end
                    codes_checked++;
                    if (next_code.last)
                        frames_closed++;
                end
            end
        end
    end

    // wait for every queued pixel to be taken and every expected code checked
    task automatic settle();
        while (pixels_taken < pixel_list.size() || code_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(input idling_t mode);
        @(posedge clk);
        send_idle_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 13 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 80 : (mode == IDLE_BOTH) ? 13 : 0;
    endtask

    // style 0: uniform; 1: rails and a base value; 2: base +/-1, many ties
    function automatic pixel_t pick_pixel(input int style, input pixel_t base);
        case (style)
            0: return pixel_t'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 2))
                    0: return 8'h00;
                    1: return 8'hFF;
                    default: return base;
                endcase
            end
            default: return pixel_t'(base + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    task automatic queue_pixels(input int count);
        int     style;
        pixel_t base;
        style = $urandom_range(0, 2);
        base  = pixel_t'($urandom_range(0, 255));
        repeat (count)
            pixel_list = {pixel_list, pick_pixel(style, base)};
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] w_val, input logic [CFG_BITS-1:0] h_val,
                             input int frames, input int extra, input idling_t mode,
                             output int queued);
        int unsigned frame_px;
        frame_px = eff_size(w_val[WIDTH_BITS-1:0], MAX_WIDTH)
                 * eff_size(h_val[HEIGHT_BITS-1:0], MAX_HEIGHT);
        settle();
        write_register(CFG_IMAGE_WIDTH, w_val);
        write_register(CFG_IMAGE_HEIGHT, h_val);
        set_idling(mode);
        repeat (frames)
            queue_pixels(frame_px);
        queue_pixels(extra);
        queued = frames * frame_px + extra;
    endtask

    initial
    begin
        int      random_items;
        int      queued;
        int      w_val;
        int      h_val;
        idling_t mode;
        random_items = 0;
        mode = IDLE_NONE;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry is 64x64: two rows and a few pixels give codes
        set_idling(IDLE_NONE);
        queue_pixels(2 * 64 + 8);
        random_items += 2 * 64 + 8;
        settle();

        // hand-built 3x3 frames: all ties, centre below all, mixed bits
        write_register(CFG_IMAGE_WIDTH, 13'd3);
        write_register(CFG_IMAGE_HEIGHT, 13'd3);
        repeat (9) pixel_list = {pixel_list, pixel_t'(8'hA5)};
        for (int i = 0; i < 9; i++)
            pixel_list = {pixel_list, pixel_t'((i == 4) ? 8'h00 : 8'hFF)};
        settle();
        write_register(CFG_IMAGE_HEIGHT, 13'd0);    // clamps to 3
        foreach (mixed_frame[i])
            pixel_list = {pixel_list, mixed_frame[i]};

        run_phase(13'd4, 13'd5, 3, 0, IDLE_NONE, queued);
        random_items += queued;
        run_phase(13'd2, 13'd3, 4, 0, IDLE_SENDER, queued);
        random_items += queued;

        // output held off while the sender keeps pushing
        run_phase(13'd7, 13'd4, 3, 0, IDLE_RECEIVER, queued);
        random_items += queued;
        @(posedge clk);
        hold_off_requests++;

        // frame cut short by the next register write
        run_phase(13'd5, 13'd6, 2, 17, IDLE_BOTH, queued);
        random_items += queued;

        // widest row: 2047 clamps to 1024, height 0 clamps to 3; short partial row
        run_phase(13'h07FF, 13'h0000, 0, 20, IDLE_BOTH, queued);
        random_items += queued;

        // exact upper limits, then bits above the width register and max height
        settle();
        write_register(CFG_IMAGE_WIDTH, 13'd1024);
        write_register(CFG_IMAGE_HEIGHT, 13'd4096);
        run_phase(13'h1803, 13'h1FFF, 0, 60, IDLE_NONE, queued);
        random_items += queued;

        while (random_items < RANDOM_ITEMS)
        begin
            w_val = $urandom_range(0, 10);
            h_val = $urandom_range(0, 8);
            mode  = idling_t'((int'(mode) + 1) % 4);
            run_phase(CFG_BITS'(w_val), CFG_BITS'(h_val), $urandom_range(1, 2),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0, mode, queued);
            random_items += queued;
        end
        settle();

        $display("run: %0d pixels in, %0d codes checked, %0d complete frames",
                 pixels_taken, codes_checked, frames_closed);
        $display("frames from 3x3 up, clamped registers, four idle mixes, one long hold-off");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
